// ===== hdl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared field widths and sequencer state codes for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int BASE_BITS = 16;
    localparam int RES_BITS  = 16;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REDUCE = 4'b0010,
        ST_STEP   = 4'b0100,
        ST_FINISH = 4'b1000
    } mexp_state_t;

endpackage

// ===== hdl/mexp_in_if.sv =====
// ----------------------------------------------------------------------------
// mexp_in_if
// Request channel: base, exponent and modulus with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mexp_in_if
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 22,
    parameter int MOD_BITS = 16
)
();
    logic                 valid;
    logic                 ready;
    logic [BASE_BITS-1:0] base;
    logic [EXP_BITS-1:0]  exponent;
    logic [MOD_BITS-1:0]  modulus;

    modport source
    (
        output valid,
        output base,
        output exponent,
        output modulus,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  base,
        input  exponent,
        input  modulus,
        output ready
    );
endinterface

// ===== hdl/mexp_out_if.sv =====
// ----------------------------------------------------------------------------
// mexp_out_if
// Response channel: power result and error flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mexp_out_if
    import mexp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [RES_BITS-1:0] power_result;
    logic                error;

    modport source
    (
        output valid,
        output power_result,
        output error,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  power_result,
        input  error,
        output ready
    );
endinterface

// ===== hdl/mexp_modmul.sv =====
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial interleaved modular multiplier: product = (a * b) mod m, taking
// one bit of b per cycle, most significant bit first. Requires a <= m, m > 0.
// ----------------------------------------------------------------------------
module mexp_modmul
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = 16,
    parameter int OP_BITS  = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MOD_BITS-1:0] a,
    input  logic [OP_BITS-1:0]  b,
    input  logic [MOD_BITS-1:0] m,
    output logic                done,
    output logic [MOD_BITS-1:0] product
);

    localparam int CNT_BITS = (OP_BITS > 1) ? $clog2(OP_BITS) : 1;
    localparam int SUM_BITS = MOD_BITS + 2;
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(OP_BITS - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic [MOD_BITS-1:0] a_reg;
    logic [OP_BITS-1:0]  b_reg;
    logic [MOD_BITS-1:0] r_reg;
    logic [MOD_BITS-1:0] r_next;

    logic [SUM_BITS-1:0] m_ext;
    logic [SUM_BITS-1:0] sum1;
    logic [SUM_BITS-1:0] sum2;
    logic [SUM_BITS-1:0] sum3;

    // 2r + a stays below 3m: two conditional subtracts bring it back under m
    always_comb
    begin
        m_ext  = {2'b00, m};
        sum1   = {1'b0, r_reg, 1'b0} + (b_reg[OP_BITS-1] ? {2'b00, a_reg} : '0);
        sum2   = (sum1 >= m_ext) ? (sum1 - m_ext) : sum1;
        sum3   = (sum2 >= m_ext) ? (sum2 - m_ext) : sum2;
        r_next = sum3[MOD_BITS-1:0];
        cnt_next = cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_next;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg <= {b_reg[OP_BITS-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule

// ===== hdl/modular_exponentiation_top.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Right-to-left square-and-multiply modular exponentiation over two
// bit-serial modular multipliers.
// ----------------------------------------------------------------------------
// One request gives one response: base ** exponent mod modulus. A zero
// modulus gives error = 1 and a result of 0; a zero exponent gives 1 (not
// reduced). Otherwise the base is first reduced, then each exponent bit up
// to the highest set one takes one pass of the square and multiply units,
// which run side by side, one multiplier bit per cycle. The block handles
// one request at a time; a finished response waits in an output register,
// so the next request may be taken while it is still unread.
// ----------------------------------------------------------------------------
module modular_exponentiation_top
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 22,
    parameter int MOD_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    mexp_in_if.sink    request,
    mexp_out_if.source response
);

    localparam int OP_BITS = (MOD_BITS > BASE_BITS) ? MOD_BITS : BASE_BITS;

    mexp_state_t          state_reg;
    mexp_state_t          state_next;
    logic                 out_valid_reg;
    logic [RES_BITS-1:0]  out_result_reg;
    logic                 out_error_reg;
    logic [RES_BITS-1:0]  pend_result_reg;
    logic                 pend_error_reg;
    logic [EXP_BITS-1:0]  exp_reg;
    logic [EXP_BITS-1:0]  exp_next;
    logic [MOD_BITS-1:0]  mod_reg;
    logic [MOD_BITS-1:0]  acc_reg;
    logic [MOD_BITS-1:0]  acc_next;
    logic [MOD_BITS-1:0]  sq_reg;

    logic                 req_accept;
    logic                 out_load;
    logic                 mul_start;
    logic [MOD_BITS-1:0]  sq_a;
    logic [OP_BITS-1:0]   sq_b;
    logic                 sq_done;
    logic [MOD_BITS-1:0]  sq_product;
    logic                 mul_done;
    logic [MOD_BITS-1:0]  mul_product;
    logic                 step_done;

    assign request.ready = (state_reg == ST_IDLE);
    assign req_accept    = request.valid && request.ready;
    assign out_load      = (state_reg == ST_FINISH) && (!out_valid_reg || response.ready);
    assign exp_next      = exp_reg >> 1;
    assign acc_next      = exp_reg[0] ? mul_product : acc_reg;
    assign step_done     = sq_done && mul_done;

    // Start both units on acceptance when modulus and exponent are nonzero
    // (base reduction), after it, and after each bit step with set bits above.
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        sq_a       = sq_reg;
        sq_b       = OP_BITS'(sq_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                sq_a = MOD_BITS'(1);
                sq_b = OP_BITS'(request.base);
                if (req_accept)
                begin
                    if (request.modulus == '0 || request.exponent == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                sq_a = sq_product;
                sq_b = OP_BITS'(sq_product);
                if (sq_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                sq_a = sq_product;
                sq_b = OP_BITS'(sq_product);
                if (step_done)
                begin
                    if (exp_next == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mul_start = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            exp_reg         <= request.exponent;
            mod_reg         <= request.modulus;
            acc_reg         <= MOD_BITS'(1);
            pend_error_reg  <= (request.modulus == '0);
            pend_result_reg <= (request.modulus == '0) ? '0 : RES_BITS'(1);
        end
        if (state_reg == ST_REDUCE && sq_done)
        begin
            sq_reg <= sq_product;
        end
        if (state_reg == ST_STEP && step_done)
        begin
            sq_reg          <= sq_product;
            acc_reg         <= acc_next;
            exp_reg         <= exp_next;
            pend_result_reg <= RES_BITS'(acc_next);
        end
        if (out_load)
        begin
            out_result_reg <= pend_result_reg;
            out_error_reg  <= pend_error_reg;
        end
    end

    // Squaring unit; also reduces the base as 1 * base mod m
    mexp_modmul #(
        .MOD_BITS (MOD_BITS),
        .OP_BITS  (OP_BITS)
    ) u_square (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (sq_a),
        .b       (sq_b),
        .m       ((state_reg == ST_IDLE) ? request.modulus : mod_reg),
        .done    (sq_done),
        .product (sq_product)
    );

    // Multiply unit: acc * sq, kept only when the current exponent bit is set
    mexp_modmul #(
        .MOD_BITS (MOD_BITS),
        .OP_BITS  (OP_BITS)
    ) u_multiply (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (sq_a),
        .b       (OP_BITS'((state_reg == ST_STEP) ? acc_next : acc_reg)),
        .m       ((state_reg == ST_IDLE) ? request.modulus : mod_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    assign response.valid        = out_valid_reg;
    assign response.power_result = out_result_reg;
    assign response.error        = out_error_reg;

endmodule

// ===== dv/tb_modular_exponentiation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_top
// Self-checking bench for the modular exponentiation block. A short table of
// corner cases is followed by random requests under several idling patterns
// and one long response hold-off. Every response is checked, in order,
// against its typed table value or a square-and-multiply predictor.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_top;
    import mexp_pkg::*;

    localparam int EXP_W       = 22;
    localparam int MOD_W       = 16;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_LIMIT = 500;
    localparam int PHASE_ITEMS = 170;
    localparam int N_DIRECTED  = 22;

    typedef struct packed {
        logic [RES_BITS-1:0] power_result;
        logic                error;
    } power_rsp_t;

    typedef struct packed {
        logic [BASE_BITS-1:0] base;
        logic [EXP_W-1:0]     exponent;
        logic [MOD_W-1:0]     modulus;
        logic                 typed;
        logic [RES_BITS-1:0]  power_result;
        logic                 error;
    } corner_row_t;

    logic clk;
    logic rst_n;

    mexp_in_if #(.EXP_BITS(EXP_W), .MOD_BITS(MOD_W)) req_if ();
    mexp_out_if                                      rsp_if ();

    modular_exponentiation_top #(
        .EXP_BITS (EXP_W),
        .MOD_BITS (MOD_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if)
    );

    power_rsp_t  pending_powers [$];
    corner_row_t corner_rows [0:N_DIRECTED-1];
    int          mismatch_count = 0;
    int          src_idle_pct   = 0;
    int          snk_stall_pct  = 0;
    int          holds_asked    = 0;
    int          holds_done     = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Right-to-left square-and-multiply; a zero exponent gives 1 unreduced.
    function automatic power_rsp_t mod_power(input logic [BASE_BITS-1:0] b,
                                             input logic [EXP_W-1:0]     e,
                                             input logic [MOD_W-1:0]     m);
        logic [63:0] acc;
        logic [63:0] sq;
        power_rsp_t  r;
        if (m == '0)
        begin
            r.power_result = '0;
            r.error        = 1'b1;
            return r;
        end
        acc = 64'd1;
        sq  = {48'd0, b};
        if (e != '0)
        begin
            for (int i = 0; i < EXP_W; i++)
            begin
                if (e[i])
                    acc = (acc * sq) % m;
                sq = (sq * sq) % m;
            end
        end
        r.power_result = acc[RES_BITS-1:0];
        r.error        = 1'b0;
        return r;
    endfunction

    // Called on a falling edge; returns on the falling edge after acceptance.
    task automatic send_request(input logic [BASE_BITS-1:0] b,
                                input logic [EXP_W-1:0]     e,
                                input logic [MOD_W-1:0]     m,
                                input power_rsp_t           want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid    <= 1'b0;
            req_if.base     <= BASE_BITS'($urandom);
            req_if.exponent <= EXP_W'($urandom);
            req_if.modulus  <= MOD_W'($urandom);
            @(negedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.base     <= b;
        req_if.exponent <= e;
        req_if.modulus  <= m;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_powers.push_back(want);
        @(negedge clk);
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int count);
        logic [BASE_BITS-1:0] b;
        logic [EXP_W-1:0]     e;
        logic [MOD_W-1:0]     m;
        int                   len;
        int                   sel;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int n = 0; n < count; n++)
        begin
            // favour the full exponent width so every bit gets exercised
            len = ($urandom_range(2) == 0) ? EXP_W : $urandom_range(EXP_W, 0);
            if (len == 0)
                e = '0;
            else
                e = EXP_W'(($urandom & ((1 << len) - 1)) | (1 << (len - 1)));
            sel = $urandom_range(19);
            case (sel)
                0:       m = '0;
                1:       m = MOD_W'(1);
                2:       m = '1;
                3:       m = MOD_W'($urandom_range(15, 2));
                default: m = MOD_W'($urandom_range(65535, 2));
            endcase
            sel = $urandom_range(15);
            case (sel)
                0:       b = '0;
                1:       b = BASE_BITS'(1);
                2:       b = '1;
                3:       b = BASE_BITS'(m);
                4:       b = BASE_BITS'(m - 1'b1);
                default: b = BASE_BITS'($urandom);
            endcase
            send_request(b, e, m, mod_power(b, e, m));
        end
    endtask

    // Sender: reset, corner table, then the random phases.
    initial
    begin
        power_rsp_t want;
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.base     = '0;
        req_if.exponent = '0;
        req_if.modulus  = '0;

        // base, exponent, modulus, typed, result, error
        corner_rows = '{
            '{16'd5,     22'd3,       16'd0,     1'b1, 16'd0,     1'b1},  // zero modulus
            '{16'hFFFF,  22'h3FFFFF,  16'd0,     1'b1, 16'd0,     1'b1},
            '{16'd7,     22'd0,       16'd13,    1'b1, 16'd1,     1'b0},  // zero exponent
            '{16'd0,     22'd0,       16'd1,     1'b1, 16'd1,     1'b0},  // unreduced one
            '{16'hFFFF,  22'd0,       16'hFFFF,  1'b1, 16'd1,     1'b0},
            '{16'd12345, 22'd1,       16'd1,     1'b1, 16'd0,     1'b0},  // modulus of one
            '{16'hFFFF,  22'h3FFFFF,  16'd1,     1'b1, 16'd0,     1'b0},
            '{16'd0,     22'd1,       16'hFFFF,  1'b1, 16'd0,     1'b0},
            '{16'd0,     22'h3FFFFF,  16'd7,     1'b1, 16'd0,     1'b0},
            '{16'd1,     22'h3FFFFF,  16'hFFFF,  1'b1, 16'd1,     1'b0},
            '{16'hFFFF,  22'd1,       16'hFFFF,  1'b1, 16'd0,     1'b0},  // base equals modulus
            '{16'hFFFF,  22'd2,       16'hFFFE,  1'b1, 16'd1,     1'b0},
            '{16'hFFFE,  22'd1,       16'hFFFF,  1'b1, 16'hFFFE,  1'b0},
            '{16'hFFFF,  22'h3FFFFF,  16'hFFFF,  1'b1, 16'd0,     1'b0},
            '{16'd2,     22'd10,      16'hFFFF,  1'b0, 16'd0,     1'b0},
            '{16'd3,     22'h3FFFFF,  16'd65521, 1'b0, 16'd0,     1'b0},
            '{16'hFFFE,  22'h3FFFFF,  16'hFFFF,  1'b0, 16'd0,     1'b0},
            '{16'd2,     22'h200000,  16'd65521, 1'b0, 16'd0,     1'b0},  // top exponent bit only
            '{16'hFFFF,  22'h3FFFFF,  16'hFFFE,  1'b0, 16'd0,     1'b0},
            '{16'd12345, 22'd54321,   16'd2,     1'b0, 16'd0,     1'b0},
            '{16'd1000,  22'd5,       16'd7,     1'b0, 16'd0,     1'b0},  // unreduced base
            '{16'd2,     22'd16,      16'hFFFF,  1'b0, 16'd0,     1'b0}
        };

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (corner_rows[i].typed)
            begin
                want.power_result = corner_rows[i].power_result;
                want.error        = corner_rows[i].error;
            end
            else
                want = mod_power(corner_rows[i].base, corner_rows[i].exponent,
                                 corner_rows[i].modulus);
            send_request(corner_rows[i].base, corner_rows[i].exponent,
                         corner_rows[i].modulus, want);
        end

        run_phase(0,  0,  PHASE_ITEMS);
        run_phase(48, 0,  PHASE_ITEMS);
        run_phase(0,  48, PHASE_ITEMS);
        run_phase(16, 16, PHASE_ITEMS);
        // hold the response side off while requests keep coming
        holds_asked = holds_asked + 1;
        run_phase(0,  0,  40);

        req_if.valid  <= 1'b0;
        snk_stall_pct = 0;
        while (pending_powers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_LIMIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver: random stalls, plus the long hold-off on request.
    initial
    begin
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done = holds_done + 1;
            end
            rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Compare each response transaction with the oldest outstanding one.
    always @(posedge clk)
    begin
        power_rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_powers.size() == 0)
            begin
                $display("%0t: unexpected response: result %0d error %0d",
                         $time, rsp_if.power_result, rsp_if.error);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = pending_powers.pop_front();
                if (rsp_if.power_result !== want.power_result)
                begin
                    $display("%0t: power_result mismatch: expected %0d, actual %0d",
                             $time, want.power_result, rsp_if.power_result);
                    mismatch_count = mismatch_count + 1;
                end
                if (rsp_if.error !== want.error)
                begin
                    $display("%0t: error mismatch: expected %0d, actual %0d",
                             $time, want.error, rsp_if.error);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mexp_pkg.sv
hdl/mexp_in_if.sv
hdl/mexp_out_if.sv
hdl/mexp_modmul.sv
hdl/modular_exponentiation_top.sv
dv/tb_modular_exponentiation_top.sv
